FILE: design/modular_inverse_ext_euclid_core_assert.svh
// Assertion macros for the checker file mie_chk.sv.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MIE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent
`define MIE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/mie_pkg.sv
`default_nettype none

package mie_pkg;

  // Operand width
  localparam int VALUE_BITS = 31;
  // Signed width of the Bezout coefficients and the partial products
  localparam int COEF_BITS  = VALUE_BITS + 3;
  // Bit counter of the divider
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

  // Modulus after reset
  localparam logic [VALUE_BITS-1:0] MODULUS_RESET = VALUE_BITS'(64'd1000000007);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take the item and the modulus, start the recurrence
    logic div_init;  // start one quotient/remainder step
    logic div_step;  // one bit of the restoring divider
    logic update;    // shift the remainder and coefficient pairs
    logic finish;    // reduce and write the output register
  } dp_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic rcur_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/mie_ctrl.sv
`default_nettype none

module mie_ctrl import mie_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.rcur_zero) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CHK;
      end
      ST_FIN: begin
        // wait for the output register to be free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/mie_dp.sv
`default_nettype none

module mie_dp import mie_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [VALUE_BITS-1:0] a_value_i,
  input  logic                  modulus_we_i,
  input  logic [VALUE_BITS-1:0] modulus_i,
  output logic [VALUE_BITS-1:0] inverse_o,
  output logic                  exists_o
);

  logic [VALUE_BITS-1:0] mod_q;
  logic [VALUE_BITS-1:0] n_q;
  logic [VALUE_BITS-1:0] r_old_q, r_cur_q;
  logic signed [COEF_BITS-1:0] s_old_q, s_cur_q;
  logic [VALUE_BITS-1:0] dvd_q, prem_q;
  logic signed [COEF_BITS-1:0] prod_q;
  logic [VALUE_BITS-1:0] inverse_q;
  logic                  exists_q;

  // Restoring divider bit: remainder and quotient times s_cur, MSB first
  logic [VALUE_BITS:0]         shifted, divisor_ext, diff;
  logic                        take;
  logic [VALUE_BITS-1:0]       prem_nxt;
  logic signed [COEF_BITS-1:0] prod_nxt;

  assign shifted     = {prem_q, dvd_q[VALUE_BITS-1]};
  assign divisor_ext = {1'b0, r_cur_q};
  assign take        = (shifted >= divisor_ext);
  assign diff        = shifted - divisor_ext;
  assign prem_nxt    = take ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
  assign prod_nxt    = (prod_q <<< 1) + (take ? s_cur_q : COEF_BITS'(0));

  // Final reduction of the coefficient into 0..n-1 (|s_old| <= n)
  logic signed [COEF_BITS-1:0] n_s, s_mag, mag_red, neg_inv, inv_full;
  logic                        s_neg, ok;

  assign n_s      = $signed({{(COEF_BITS-VALUE_BITS){1'b0}}, n_q});
  assign s_neg    = s_old_q[COEF_BITS-1];
  assign s_mag    = s_neg ? -s_old_q : s_old_q;
  assign mag_red  = (s_mag >= n_s) ? (s_mag - n_s) : s_mag;
  assign neg_inv  = (mag_red == '0) ? COEF_BITS'(0) : (n_s - mag_red);
  assign inv_full = s_neg ? neg_inv : mag_red;
  assign ok       = (r_old_q == VALUE_BITS'(1)) && (n_q != '0);

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RESET;
    end else if (modulus_we_i) begin
      mod_q <= modulus_i;
    end
  end

  // Euclid recurrence and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= mod_q;
      r_old_q <= a_value_i;
      r_cur_q <= mod_q;
      s_old_q <= COEF_BITS'(1);
      s_cur_q <= '0;
    end else if (cmd_i.update) begin
      r_old_q <= r_cur_q;
      r_cur_q <= prem_q;
      s_old_q <= s_cur_q;
      s_cur_q <= s_old_q - prod_q;
    end
    if (cmd_i.div_init) begin
      dvd_q  <= r_old_q;
      prem_q <= '0;
      prod_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= dvd_q << 1;
      prem_q <= prem_nxt;
      prod_q <= prod_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      inverse_q <= ok ? inv_full[VALUE_BITS-1:0] : '0;
      exists_q  <= ok;
    end
  end

  assign sts_o.rcur_zero = (r_cur_q == '0);
  assign inverse_o       = inverse_q;
  assign exists_o        = exists_q;

endmodule

`default_nettype wire

FILE: design/modular_inverse_ext_euclid_core.sv
// Modular inverse by the extended Euclidean algorithm.
// Input channel: a_value_i with in_valid_i / in_stall_o. One item per result.
// Output channel: inverse_o and exists_o with out_valid_o / out_stall_i.
// exists_o is 1 when gcd(a_value, modulus) is 1 and the modulus is nonzero; otherwise inverse_o is 0.
// Configuration: modulus_we_i writes modulus_i into the modulus register,
// which resets to 1000000007. Write it only while no item is in flight.
// One item is worked at a time. Each Euclid step runs a shared restoring
// divider one bit per cycle, between a check state and an update state.
// The result enters the output register after the last step, at most 45
// steps for 31-bit operands; the next item can be accepted in the cycle
// after. in_stall_o is high from acceptance until the result enters the
// output register.
// The output register holds the result while out_stall_i is high; a new item
// can be accepted while it waits, and that item's result waits in turn for
// the register to empty before it is written.
// Reset clears the controller and the output valid and restores the modulus.
`default_nettype none

module modular_inverse_ext_euclid_core import mie_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] a_value_i,
  input  logic                  modulus_we_i,
  input  logic [VALUE_BITS-1:0] modulus_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] inverse_o,
  output logic                  exists_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller
  mie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  mie_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .a_value_i    (a_value_i),
    .modulus_we_i (modulus_we_i),
    .modulus_i    (modulus_i),
    .inverse_o    (inverse_o),
    .exists_o     (exists_o)
  );

endmodule

`default_nettype wire

FILE: design/mie_chk.sv
`default_nettype none
`include "modular_inverse_ext_euclid_core_assert.svh"

module mie_chk import mie_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [VALUE_BITS-1:0] inverse_o,
  input  logic                  exists_o
);

  // Result held while stalled
  `MIE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // Busy after taking an item
  `MIE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A new result frees the input side
  `MIE_ASSERT_IMPL(a_ready_on_result, $rose(out_valid_o), !in_stall_o)

  // No inverse means a zero value
  `MIE_ASSERT_IMPL(a_none_is_zero, out_valid_o && !exists_o, inverse_o == '0)

endmodule

bind modular_inverse_ext_euclid_core mie_chk u_mie_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .inverse_o   (inverse_o),
  .exists_o    (exists_o)
);

`default_nettype wire
